[design/hwcs_pkg.sv]
// Shared types and constants for the heartbeat watchdog close sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hwcs_pkg;

  // Input transaction kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_HOST = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // Commands sent to the dome controller on a tick
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_GUARD = 2'd1,
    CMD_A     = 2'd2,
    CMD_B     = 2'd3
  } serial_cmd_t;

  // Heartbeat LED modes
  typedef enum logic [1:0] {
    LED_OFF     = 2'd0,
    LED_ARMED   = 2'd1,
    LED_TRIPPED = 2'd2
  } led_mode_t;

  // Configuration register indexes
  localparam logic CFG_CLOSE_STEPS  = 1'b0;
  localparam logic CFG_BUMPER_GUARD = 1'b1;

  localparam logic [7:0] MAX_ARM        = 8'd240;
  localparam logic [7:0] SIREN_REQUEST  = 8'hFF;
  localparam logic [3:0] SIREN_LEAD     = 4'd10;
  localparam logic [7:0] SIREN_LEAD_CD  = 8'd10;
  localparam logic [7:0] STATUS_CLOSING = 8'd254;
  localparam logic [7:0] STATUS_TRIPPED = 8'd255;
  localparam logic [2:0] GUARD_COUNT    = 3'd4;
  localparam logic [7:0] CLOSE_STEPS_RST = 8'd20;

  // Controller cancel bytes
  localparam logic [7:0] CTRL_CANCEL_A   = 8'h58; // 'X'
  localparam logic [7:0] CTRL_CANCEL_B   = 8'h59; // 'Y'
  localparam logic [7:0] CTRL_CANCEL_ALL = 8'h30; // '0'

  // Result word layout
  typedef struct packed {
    logic [7:0]  status_byte;
    logic        status_valid;
    logic        blink_led;
    logic [1:0]  heartbeat_led;
    logic        siren_on;
    logic        relay_on;
    logic [1:0]  serial_code;
  } result_t;

endpackage

`default_nettype wire

[design/heartbeat_watchdog_close_sequencer.sv]
// Top level of the heartbeat watchdog close sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat watchdog: host bytes arm a countdown of half-second ticks, and when
// it runs out the block enables the controller relay and sends guard, shutter A
// and shutter B close commands, one per tick. Every input transaction (host
// byte, controller byte or tick, selected by in_tuser) yields exactly one result
// transaction. The watchdog state updates when an input is accepted and the
// result lands in a single output register, so a new input is taken every
// cycle as long as the output register is empty or being drained in the same
// cycle. Configuration writes are applied at once and should only be made
// while no transaction is in flight.
module heartbeat_watchdog_close_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [1:0] serial_code, [2] relay_on, [3] siren_on,
                                       // [5:4] heartbeat_led, [6] blink_led,
                                       // [7] status_valid, [15:8] status_byte
);

  // Configuration registers
  logic [7:0] close_steps_r;
  logic       bumper_guard_r;

  // Watchdog state
  logic [7:0] countdown_r,   countdown_nxt;
  logic       closing_r,     closing_nxt;
  logic       sticky_r,      sticky_nxt;
  logic [7:0] steps_a_r,     steps_a_nxt;
  logic [7:0] steps_b_r,     steps_b_nxt;
  logic [2:0] guard_r,       guard_nxt;
  logic [3:0] siren_steps_r, siren_steps_nxt;
  logic       siren_level_r, siren_level_nxt;
  logic       blink_r,       blink_nxt;
  logic [1:0] led_r,         led_nxt;

  // Output register
  logic                out_valid_r;
  hwcs_pkg::result_t   out_data_r, result_nxt;

  logic in_accept;

  // Take a new transaction when the output register is free or draining
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_steps_r  <= hwcs_pkg::CLOSE_STEPS_RST;
      bumper_guard_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwcs_pkg::CFG_CLOSE_STEPS:  close_steps_r  <= cfg_wdata;
        hwcs_pkg::CFG_BUMPER_GUARD: bumper_guard_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next watchdog state and result for the transaction at the input
  always_comb begin
    logic       trip;
    logic [7:0] cd1;
    logic [3:0] siren1;
    logic [7:0] a1, b1;
    logic [2:0] g1;
    logic       sticky1, closing1;
    logic [1:0] code;
    logic       sticky_after;

    countdown_nxt   = countdown_r;
    closing_nxt     = closing_r;
    sticky_nxt      = sticky_r;
    steps_a_nxt     = steps_a_r;
    steps_b_nxt     = steps_b_r;
    guard_nxt       = guard_r;
    siren_steps_nxt = siren_steps_r;
    siren_level_nxt = siren_level_r;
    blink_nxt       = blink_r;
    led_nxt         = led_r;

    trip     = 1'b0;
    cd1      = 8'd0;
    siren1   = 4'd0;
    a1       = 8'd0;
    b1       = 8'd0;
    g1       = 3'd0;
    sticky1  = 1'b0;
    closing1 = 1'b0;
    code     = hwcs_pkg::CMD_NONE;
    sticky_after = 1'b0;

    result_nxt = '0;

    unique case (in_tuser)
      hwcs_pkg::KIND_HOST: begin
        if (in_tdata == hwcs_pkg::SIREN_REQUEST) begin
          siren_steps_nxt = hwcs_pkg::SIREN_LEAD;
        end
        if (in_tdata <= hwcs_pkg::MAX_ARM) begin
          // Zero disarms and clears the trip
          sticky_after = (in_tdata == 8'd0) ? 1'b0 : sticky_r;
          if (in_tdata == 8'd0) begin
            sticky_nxt  = 1'b0;
            closing_nxt = 1'b0;
          end
          if (!sticky_after) begin
            countdown_nxt = in_tdata;
            led_nxt = (in_tdata != 8'd0) ? hwcs_pkg::LED_ARMED : hwcs_pkg::LED_OFF;
          end
        end
      end
      hwcs_pkg::KIND_CTRL: begin
        // Cancel pending close steps
        if (in_tdata == hwcs_pkg::CTRL_CANCEL_A) begin
          steps_a_nxt = 8'd0;
        end else if (in_tdata == hwcs_pkg::CTRL_CANCEL_B) begin
          steps_b_nxt = 8'd0;
        end else if (in_tdata == hwcs_pkg::CTRL_CANCEL_ALL) begin
          steps_a_nxt = 8'd0;
          steps_b_nxt = 8'd0;
        end
      end
      hwcs_pkg::KIND_TICK: begin
        blink_nxt = !blink_r;

        // Advance the countdown; trip when it reaches zero
        trip   = (countdown_r == 8'd1);
        cd1    = (countdown_r != 8'd0) ? countdown_r - 8'd1 : countdown_r;
        siren1 = (countdown_r == hwcs_pkg::SIREN_LEAD_CD) ? hwcs_pkg::SIREN_LEAD
                                                           : siren_steps_r;
        a1       = trip ? close_steps_r : steps_a_r;
        b1       = trip ? close_steps_r : steps_b_r;
        g1       = (trip && bumper_guard_r) ? hwcs_pkg::GUARD_COUNT : guard_r;
        sticky1  = sticky_r || trip;
        closing1 = closing_r || trip;
        countdown_nxt = cd1;
        sticky_nxt    = sticky1;
        if (trip) begin
          led_nxt = hwcs_pkg::LED_TRIPPED;
        end

        // Issue one command per tick, guard resets first
        steps_a_nxt = a1;
        steps_b_nxt = b1;
        guard_nxt   = g1;
        if (g1 != 3'd0) begin
          code      = hwcs_pkg::CMD_GUARD;
          guard_nxt = g1 - 3'd1;
        end else if (a1 != 8'd0) begin
          code        = hwcs_pkg::CMD_A;
          steps_a_nxt = a1 - 8'd1;
        end else if (b1 != 8'd0) begin
          code        = hwcs_pkg::CMD_B;
          steps_b_nxt = b1 - 8'd1;
        end

        // Drop the relay once both shutters are done
        closing_nxt = closing1 && !(steps_a_nxt == 8'd0 && steps_b_nxt == 8'd0);

        // Run the siren down
        siren_steps_nxt = siren1;
        if (siren1 != 4'd0) begin
          siren_steps_nxt = siren1 - 4'd1;
          siren_level_nxt = (siren1 != 4'd1);
        end

        result_nxt.serial_code  = code;
        result_nxt.status_valid = 1'b1;
        result_nxt.status_byte  = closing_nxt ? hwcs_pkg::STATUS_CLOSING :
                                  sticky1     ? hwcs_pkg::STATUS_TRIPPED : cd1;
      end
      default: ;
    endcase

    result_nxt.relay_on      = closing_nxt;
    result_nxt.siren_on      = siren_level_nxt;
    result_nxt.heartbeat_led = led_nxt;
    result_nxt.blink_led     = blink_nxt;
  end

  // Watchdog state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r   <= '0;
      closing_r     <= 1'b0;
      sticky_r      <= 1'b0;
      steps_a_r     <= '0;
      steps_b_r     <= '0;
      guard_r       <= '0;
      siren_steps_r <= '0;
      siren_level_r <= 1'b0;
      blink_r       <= 1'b0;
      led_r         <= hwcs_pkg::LED_OFF;
    end else if (in_accept) begin
      countdown_r   <= countdown_nxt;
      closing_r     <= closing_nxt;
      sticky_r      <= sticky_nxt;
      steps_a_r     <= steps_a_nxt;
      steps_b_r     <= steps_b_nxt;
      guard_r       <= guard_nxt;
      siren_steps_r <= siren_steps_nxt;
      siren_level_r <= siren_level_nxt;
      blink_r       <= blink_nxt;
      led_r         <= led_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result_nxt;
    end
  end

  // The relay is only on while the watchdog is tripped
  a_closing_needs_trip: assert property (@(posedge clk) disable iff (!rst_n)
    closing_r |-> sticky_r)
    else $error("closing active without sticky trip");

  // Guard reset count never exceeds its load value
  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    guard_r <= hwcs_pkg::GUARD_COUNT)
    else $error("guard step count out of range");

  // A tick that runs the countdown out trips the watchdog
  a_tick_trips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == hwcs_pkg::KIND_TICK && countdown_r == 8'd1)
      |=> (sticky_r && out_tvalid && out_data_r.heartbeat_led == hwcs_pkg::LED_TRIPPED))
    else $error("countdown expiry did not trip");

  // A stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while result is stalled");

endmodule

`default_nettype wire

[tb/hwcs_result_checker.sv]
// Result checker for the heartbeat watchdog close sequencer: predicts and compares every result.
`timescale 1ns / 1ps

module hwcs_result_checker
  import hwcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // [1:0] serial_code, [2] relay_on, [3] siren_on,
                                       // [5:4] heartbeat_led, [6] blink_led,
                                       // [7] status_valid, [15:8] status_byte
  output int unsigned      fail_count,
  output int unsigned      pending
);

  // Register copies
  logic [7:0] close_steps_q;
  logic       guard_en_q;

  // Watchdog and sequencer state
  logic [7:0] countdown_q;
  logic       closing_q;
  logic       tripped_q;
  logic [7:0] steps_a_q;
  logic [7:0] steps_b_q;
  logic [2:0] guard_left_q;
  logic [3:0] siren_left_q;
  logic       siren_q;
  logic       blink_q;
  led_mode_t  led_q;

  // Results predicted for accepted transactions, oldest first
  result_t awaited_results[$];

  // Apply one input transaction to the watchdog state and return the status it reports
  function automatic result_t advance_watchdog(input logic [1:0] kind, input logic [7:0] b);
    result_t     r;
    serial_cmd_t cmd;
    logic        reported;
    logic [7:0]  status;
    cmd      = CMD_NONE;
    reported = 1'b0;
    status   = 8'd0;
    case (kind)
      KIND_HOST: begin
        if (b == SIREN_REQUEST) siren_left_q = SIREN_LEAD;
        if (b <= MAX_ARM) begin
          // a zero disarms and clears the trip; nonzero reloads unless tripped
          if (b == 8'd0) begin
            tripped_q = 1'b0;
            closing_q = 1'b0;
          end
          if (!tripped_q) begin
            countdown_q = b;
            led_q       = (b != 8'd0) ? LED_ARMED : LED_OFF;
          end
        end
      end
      KIND_CTRL: begin
        if (b == CTRL_CANCEL_A) begin
          steps_a_q = 8'd0;
        end else if (b == CTRL_CANCEL_B) begin
          steps_b_q = 8'd0;
        end else if (b == CTRL_CANCEL_ALL) begin
          steps_a_q = 8'd0;
          steps_b_q = 8'd0;
        end
      end
      KIND_TICK: begin
        blink_q = ~blink_q;
        // count down; trip loads the close steps
        if (countdown_q != 8'd0) begin
          if (countdown_q == SIREN_LEAD_CD) siren_left_q = SIREN_LEAD;
          countdown_q = countdown_q - 8'd1;
          if (countdown_q == 8'd0) begin
            steps_a_q = close_steps_q;
            steps_b_q = close_steps_q;
            led_q     = LED_TRIPPED;
            tripped_q = 1'b1;
            closing_q = 1'b1;
            if (guard_en_q) guard_left_q = GUARD_COUNT;
          end
        end
        // one command per tick: guard resets, then shutter A, then shutter B
        if (guard_left_q != 3'd0) begin
          cmd          = CMD_GUARD;
          guard_left_q = guard_left_q - 3'd1;
        end else if (steps_a_q != 8'd0) begin
          cmd       = CMD_A;
          steps_a_q = steps_a_q - 8'd1;
        end else if (steps_b_q != 8'd0) begin
          cmd       = CMD_B;
          steps_b_q = steps_b_q - 8'd1;
        end
        if (closing_q && steps_a_q == 8'd0 && steps_b_q == 8'd0) closing_q = 1'b0;
        // siren runs while its step count lasts
        if (siren_left_q != 4'd0) begin
          siren_q      = 1'b1;
          siren_left_q = siren_left_q - 4'd1;
          if (siren_left_q == 4'd0) siren_q = 1'b0;
        end
        reported = 1'b1;
        status   = closing_q ? STATUS_CLOSING : tripped_q ? STATUS_TRIPPED : countdown_q;
      end
      default: ;
    endcase
    r.serial_code   = cmd;
    r.relay_on      = closing_q;
    r.siren_on      = siren_q;
    r.heartbeat_led = led_q;
    r.blink_led     = blink_q;
    r.status_valid  = reported;
    r.status_byte   = status;
    return r;
  endfunction

  // Compare accepted results, track register writes, predict accepted inputs
  always @(posedge clk) begin : sample
    result_t seen;
    result_t want;
    if (!rst_n) begin
      close_steps_q = CLOSE_STEPS_RST;
      guard_en_q    = 1'b0;
      countdown_q   = 8'd0;
      closing_q     = 1'b0;
      tripped_q     = 1'b0;
      steps_a_q     = 8'd0;
      steps_b_q     = 8'd0;
      guard_left_q  = 3'd0;
      siren_left_q  = 4'd0;
      siren_q       = 1'b0;
      blink_q       = 1'b0;
      led_q         = LED_OFF;
      awaited_results.delete();
      fail_count    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %h arrived with no transaction awaiting it", $time, seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen.serial_code !== want.serial_code || seen.relay_on !== want.relay_on ||
              seen.siren_on !== want.siren_on || seen.heartbeat_led !== want.heartbeat_led ||
              seen.blink_led !== want.blink_led || seen.status_valid !== want.status_valid ||
              seen.status_byte !== want.status_byte) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch", $time);
              $display("  want cmd=%0d relay=%0d siren=%0d led=%0d blink=%0d valid=%0d status=%0d",
                       want.serial_code, want.relay_on, want.siren_on, want.heartbeat_led,
                       want.blink_led, want.status_valid, want.status_byte);
              $display("  got  cmd=%0d relay=%0d siren=%0d led=%0d blink=%0d valid=%0d status=%0d",
                       seen.serial_code, seen.relay_on, seen.siren_on, seen.heartbeat_led,
                       seen.blink_led, seen.status_valid, seen.status_byte);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOSE_STEPS:  close_steps_q = cfg_wdata;
          CFG_BUMPER_GUARD: guard_en_q    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(advance_watchdog(in_tuser, in_tdata));
    end
    pending = awaited_results.size();
  end

endmodule

[tb/heartbeat_watchdog_close_sequencer_tb.sv]
// Testbench top for the heartbeat watchdog close sequencer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module heartbeat_watchdog_close_sequencer_tb;
  import hwcs_pkg::*;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         HOLDOFF_CYCLES = 40;
  localparam int         DRAIN_LIMIT    = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_value
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] serial_code, [2] relay_on, [3] siren_on,
                           // [5:4] heartbeat_led, [6] blink_led,
                           // [7] status_valid, [15:8] status_byte

  int unsigned fail_count;
  int unsigned pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          items_sent;
  int          stall_reqs;
  int          stalls_done;
  int          hold_left;

  heartbeat_watchdog_close_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hwcs_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random backpressure, plus long hold-offs on request
  initial begin
    out_tready  = 1'b0;
    stalls_done = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_reqs != stalls_done) begin
        stalls_done++;
        hold_left  = HOLDOFF_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one transaction, idling first at random; return at the falling edge after acceptance
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    // count only transactions that do something
    if (kind == KIND_TICK || (kind == KIND_HOST && (b <= MAX_ARM || b == SIREN_REQUEST)) ||
        (kind == KIND_CTRL && (b == CTRL_CANCEL_A || b == CTRL_CANCEL_B ||
                               b == CTRL_CANCEL_ALL)))
      items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_for_results();
    int waited;
    in_tvalid = 1'b0;
    waited    = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic apply_settings(input logic [7:0] steps, input logic [7:0] guard_word);
    cfg_we    = 1'b1;
    cfg_index = CFG_CLOSE_STEPS;
    cfg_wdata = steps;
    @(negedge clk);
    cfg_index = CFG_BUMPER_GUARD;
    cfg_wdata = guard_word;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly arm-and-run sequences with random cancels and siren requests, some noise
  task automatic run_traffic(input int target);
    int         stop_at;
    int         arm;
    int         n_ticks;
    int         pick;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(19) == 0) begin
          arm     = ($urandom_range(1) == 0) ? int'(MAX_ARM) : $urandom_range(15, 239);
          n_ticks = $urandom_range(1, 20);
        end else begin
          arm     = $urandom_range(1, 14);
          n_ticks = arm + $urandom_range(0, 12);
        end
        send_item(KIND_HOST, 8'(arm));
        repeat (n_ticks) begin
          pick = $urandom_range(99);
          if (pick < 4)       send_item(KIND_CTRL, CTRL_CANCEL_A);
          else if (pick < 8)  send_item(KIND_CTRL, CTRL_CANCEL_B);
          else if (pick < 11) send_item(KIND_CTRL, CTRL_CANCEL_ALL);
          else if (pick < 14) send_item(KIND_CTRL, 8'($urandom_range(255)));
          else if (pick < 17) send_item(KIND_HOST, SIREN_REQUEST);
          else if (pick < 19) send_item(KIND_HOST, 8'($urandom_range(255)));
          send_item(KIND_TICK, 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 60) send_item(KIND_HOST, 8'd0);
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_CLOSE_STEPS;
    cfg_wdata     = 8'd0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'd0;
    in_tuser      = KIND_HOST;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    stall_reqs    = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored bytes, siren request, reload, siren lead, trip with guard,
    // reload while tripped, cancels, clear with steps still pending
    apply_settings(8'd2, 8'h01);
    send_item(KIND_HOST, 8'd0);
    send_item(KIND_HOST, 8'd241);
    send_item(KIND_HOST, 8'd254);
    send_item(KIND_CTRL, 8'h41);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_HOST, SIREN_REQUEST);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_HOST, MAX_ARM);
    send_item(KIND_HOST, 8'd11);
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_TICK, 8'h5A);
    send_item(KIND_HOST, 8'd1);
    send_item(KIND_TICK, 8'hA5);
    send_item(KIND_HOST, 8'd5);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_CTRL, CTRL_CANCEL_A);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_HOST, 8'd0);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_CTRL, CTRL_CANCEL_ALL);
    send_item(KIND_CTRL, CTRL_CANCEL_B);
    send_item(KIND_TICK, 8'h00);
    wait_for_results();

    // Zero close steps: relay drops on the tripping tick; upper guard bits are masked
    apply_settings(8'd0, 8'hFE);
    send_item(KIND_HOST, 8'd1);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
    wait_for_results();

    // Sender idles lightly, receiver heavily, with one long hold-off
    apply_settings(8'd3, 8'h01);
    send_idle_pct = 20;
    recv_idle_pct = 72;
    stall_reqs++;
    run_traffic(100);
    wait_for_results();

    // Full close count, sender idles heavily
    apply_settings(8'hFF, 8'h00);
    send_idle_pct = 72;
    recv_idle_pct = 20;
    run_traffic(100);
    wait_for_results();

    // No idling, back-to-back, with a hold-off to fill the block
    apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_reqs++;
    run_traffic(100);
    wait_for_results();

    apply_settings(8'd0, 8'h01);
    run_traffic(100);
    wait_for_results();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/hwcs_pkg.sv
design/heartbeat_watchdog_close_sequencer.sv
tb/hwcs_result_checker.sv
tb/heartbeat_watchdog_close_sequencer_tb.sv
